// ===== rtl/core/bgm_pkg.sv =====
// ----------------------------------------------------------------------------
// bgm_pkg
// Shared widths, codes and interface types of the battery gauge monitor core.
// ----------------------------------------------------------------------------
package bgm_pkg;

  // stream payload widths (byte padded)
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 40;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_RCOMP_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_HOT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_COLD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_PT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_PT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MV     = 3'd5;

  // poll interval codes
  localparam logic [1:0] POLL_BOOT   = 2'd0;
  localparam logic [1:0] POLL_FAST   = 2'd1;
  localparam logic [1:0] POLL_NORMAL = 2'd2;
  localparam logic [1:0] POLL_NONE   = 2'd3;

  // bit-serial multiply lanes
  localparam int unsigned LANE_STEPS = 16;
  localparam int unsigned LANE_CNT_W = 5;

  // shared divider: full run gives 17 quotient bits, narrow run gives 8
  localparam int unsigned DIV_NUM_W  = 31;
  localparam int unsigned DIV_DEN_W  = 24;
  localparam int unsigned DIV_QUO_W  = 17;
  localparam int unsigned DIV_NARROW = 8;
  localparam int unsigned DIV_SH_W   = DIV_DEN_W + DIV_QUO_W - 1;
  localparam int unsigned DIV_CNT_W  = 5;

  localparam logic [DIV_DEN_W-1:0] RCOMP_SCALE   = 24'd1000;
  localparam logic [17:0]          RCOMP_NUM_MAX = 18'd255999;
  localparam logic [6:0]           CAP_MAX       = 7'd100;
  localparam logic [6:0]           CAP_RECHARGE  = 7'd99;

  typedef struct packed {
    logic start;
    logic narrow;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_QUO_W-1:0] quo;
  } div_stat_t;

  typedef struct packed {
    logic        done;
    logic        d_pos;   // temperature above 20 degrees
    logic [30:0] pos;     // charge * 19531
    logic [29:0] neg;     // empty * 1000000
    logic [23:0] den;     // (full - empty) * 10000
    logic [22:0] prod;    // |deg - 20| * coef
    logic [17:0] base;    // rcomp_base * 1000
  } lane_res_t;

endpackage

// ===== rtl/core/bgm_mul_lanes.sv =====
// ----------------------------------------------------------------------------
// bgm_mul_lanes
// Five bit-serial shift-add multipliers that run side by side for 16 steps.
// ----------------------------------------------------------------------------
module bgm_mul_lanes (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        charge_i,
  input  logic signed [10:0] temp_i,
  input  logic [7:0]         rcomp_base_i,
  input  logic [15:0]        coef_hot_i,
  input  logic [15:0]        coef_cold_i,
  input  logic [9:0]         full_i,
  input  logic [9:0]         empty_i,
  output bgm_pkg::lane_res_t res_o
);
  import bgm_pkg::*;

  logic [LANE_CNT_W-1:0] cnt_q;
  logic                  busy_q, done_q;

  // multiplier bits shift right, multiplicands shift left
  logic [15:0] mr_pos_q;
  logic [9:0]  mr_neg_q, mr_den_q;
  logic [6:0]  mr_prod_q;
  logic [7:0]  mr_base_q;
  logic [29:0] md_pos_q;
  logic [28:0] md_neg_q;
  logic [22:0] md_den_q;
  logic [21:0] md_prod_q;
  logic [16:0] md_base_q;
  logic [30:0] acc_pos_q;
  logic [29:0] acc_neg_q;
  logic [23:0] acc_den_q;
  logic [22:0] acc_prod_q;
  logic [17:0] acc_base_q;
  logic        d_pos_q;

  // temperature to whole degrees, truncated toward zero (x/10 = x*205 >> 11)
  logic        t_neg;
  logic [10:0] t_abs;
  logic [18:0] t_scaled;
  logic [6:0]  deg_mag;
  logic [8:0]  deg;
  logic [8:0]  d;
  logic        d_pos;
  logic [6:0]  d_mag;
  logic [9:0]  span;

  always_comb begin
    t_neg    = temp_i[10];
    t_abs    = t_neg ? 11'(-temp_i) : 11'(temp_i);
    t_scaled = 19'(t_abs) * 19'd205;
    deg_mag  = t_scaled[17:11];
    deg      = t_neg ? 9'(-{2'b00, deg_mag}) : {2'b00, deg_mag};
    d        = deg - 9'd20;
    d_pos    = !d[8] && (d != '0);
    d_mag    = d[8] ? 7'(-d) : d[6:0];
    span     = (full_i > empty_i) ? (full_i - empty_i) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LANE_CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= LANE_CNT_W'(LANE_STEPS);
      end else if (busy_q) begin
        cnt_q  <= cnt_q - 1'b1;
        busy_q <= cnt_q != LANE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mr_pos_q   <= charge_i;
      mr_neg_q   <= empty_i;
      mr_den_q   <= span;
      mr_prod_q  <= d_mag;
      mr_base_q  <= rcomp_base_i;
      md_pos_q   <= 30'd19531;
      md_neg_q   <= 29'd1000000;
      md_den_q   <= 23'd10000;
      md_prod_q  <= {6'b0, (d_pos ? coef_hot_i : coef_cold_i)};
      md_base_q  <= 17'd1000;
      acc_pos_q  <= '0;
      acc_neg_q  <= '0;
      acc_den_q  <= '0;
      acc_prod_q <= '0;
      acc_base_q <= '0;
      d_pos_q    <= d_pos;
    end else if (busy_q) begin
      acc_pos_q  <= acc_pos_q  + (mr_pos_q[0]  ? 31'(md_pos_q)  : '0);
      acc_neg_q  <= acc_neg_q  + (mr_neg_q[0]  ? 30'(md_neg_q)  : '0);
      acc_den_q  <= acc_den_q  + (mr_den_q[0]  ? 24'(md_den_q)  : '0);
      acc_prod_q <= acc_prod_q + (mr_prod_q[0] ? 23'(md_prod_q) : '0);
      acc_base_q <= acc_base_q + (mr_base_q[0] ? 18'(md_base_q) : '0);
      mr_pos_q   <= mr_pos_q  >> 1;
      mr_neg_q   <= mr_neg_q  >> 1;
      mr_den_q   <= mr_den_q  >> 1;
      mr_prod_q  <= mr_prod_q >> 1;
      mr_base_q  <= mr_base_q >> 1;
      md_pos_q   <= md_pos_q  << 1;
      md_neg_q   <= md_neg_q  << 1;
      md_den_q   <= md_den_q  << 1;
      md_prod_q  <= md_prod_q << 1;
      md_base_q  <= md_base_q << 1;
    end
  end

  always_comb begin
    res_o.done  = done_q;
    res_o.d_pos = d_pos_q;
    res_o.pos   = acc_pos_q;
    res_o.neg   = acc_neg_q;
    res_o.den   = acc_den_q;
    res_o.prod  = acc_prod_q;
    res_o.base  = acc_base_q;
  end

endmodule

// ===== rtl/core/bgm_div.sv =====
// ----------------------------------------------------------------------------
// bgm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bgm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bgm_pkg::div_req_t              req_i,
  input  logic [bgm_pkg::DIV_NUM_W-1:0]  num_i,
  input  logic [bgm_pkg::DIV_DEN_W-1:0]  den_i,
  output bgm_pkg::div_stat_t             stat_o
);
  import bgm_pkg::*;

  logic [DIV_NUM_W-1:0] rem_q;
  logic [DIV_SH_W-1:0]  dsh_q;
  logic [DIV_QUO_W-1:0] quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;
  logic                 ge;

  // narrow run only used when the quotient is known to fit in 8 bits
  assign ge = {{(DIV_SH_W-DIV_NUM_W){1'b0}}, rem_q} >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.narrow ? DIV_CNT_W'(DIV_NARROW) : DIV_CNT_W'(DIV_QUO_W);
      end else if (busy_q) begin
        cnt_q  <= cnt_q - 1'b1;
        busy_q <= cnt_q != DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= num_i;
      quo_q <= '0;
      if (req_i.narrow) begin
        dsh_q <= DIV_SH_W'({den_i, {(DIV_NARROW-1){1'b0}}});
      end else begin
        dsh_q <= {den_i, {(DIV_QUO_W-1){1'b0}}};
      end
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q[DIV_NUM_W-1:0];
      end
      quo_q <= {quo_q[DIV_QUO_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  always_comb begin
    stat_o.done = done_q;
    stat_o.quo  = quo_q;
  end

endmodule

// ===== rtl/core/battery_gauge_monitor_step_core.sv =====
// ----------------------------------------------------------------------------
// battery_gauge_monitor_step_core
// Battery gauge poll processor: capacity, millivolts, RCOMP, poll decisions.
// ----------------------------------------------------------------------------
// One poll is handled at a time. Each poll runs through the bit-serial multiply
// lanes, then through the one shared restoring divider for the 17-bit capacity
// quotient and the 8-bit RCOMP quotient, and its result is then loaded into the
// output register. A new poll is accepted only once that load has happened. A
// finished result waits in the output register, so the next poll is accepted
// while it is still pending. Configuration writes are always accepted.
module battery_gauge_monitor_step_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // charge_word[15:0], voltage_word[31:16], temperature_tenths[42:32],
  // booting[43], health_good[44], not_charging[45], zero pad[47:46]
  input  logic [bgm_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // capacity_percent[6:0], voltage_mv[19:7], rcomp_byte[27:20],
  // recharge_request[28], change_notice[29], poll_code[31:30],
  // power_off_request[32], zero pad[39:33]
  output logic [bgm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [bgm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bgm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bgm_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_CAP, ST_RC, ST_OUT} state_e;

  state_e state_q;

  // configuration
  logic [7:0]  rcomp_base_q;
  logic [15:0] coef_hot_q, coef_cold_q;
  logic [9:0]  full_q, empty_q;
  logic [12:0] low_mv_q;

  // per-poll holding registers
  logic [12:0] mv_q;
  logic        booting_q, health_q, nchg_q;
  logic [6:0]  cap_q;
  logic [7:0]  rcomp_q;

  // persistent state
  logic [6:0]  last_cap_q;
  logic [1:0]  uv_cnt_q;

  // output register
  logic        m_valid_q;
  logic [6:0]  o_cap_q;
  logic [12:0] o_mv_q;
  logic [7:0]  o_rcomp_q;
  logic        o_recharge_q, o_notice_q, o_pwr_off_q;
  logic [1:0]  o_poll_q;

  logic        in_accept;
  logic [14:0] mv_x5;
  lane_res_t   lane_res;
  div_req_t    div_req;
  div_stat_t   div_stat;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;

  logic                 cap_ok;
  logic [DIV_NUM_W-1:0] cap_num;
  logic [DIV_DEN_W-1:0] cap_den;
  logic [23:0]          rc_sum;
  logic                 rc_neg;
  logic [17:0]          rc_num;
  logic [6:0]           cap_res;

  logic       out_load;
  logic       changed, want_recharge;
  logic [1:0] poll_d, uv_cnt_d;
  logic       pwr_off_d;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // millivolts = ((word >> 4) * 5) >> 2
  assign mv_x5 = {3'b000, s_axis_tdata_i[31:20]} + {1'b0, s_axis_tdata_i[31:20], 2'b00};

  bgm_mul_lanes u_lanes (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_accept),
    .charge_i     (s_axis_tdata_i[15:0]),
    .temp_i       (s_axis_tdata_i[42:32]),
    .rcomp_base_i (rcomp_base_q),
    .coef_hot_i   (coef_hot_q),
    .coef_cold_i  (coef_cold_q),
    .full_i       (full_q),
    .empty_i      (empty_q),
    .res_o        (lane_res)
  );

  // capacity operands; an empty span or negative numerator divides 0 by 1
  always_comb begin
    cap_ok  = (full_q > empty_q) && (lane_res.pos >= {1'b0, lane_res.neg});
    cap_num = cap_ok ? (lane_res.pos - {1'b0, lane_res.neg}) : '0;
    cap_den = cap_ok ? lane_res.den : DIV_DEN_W'(1);
  end

  // rcomp numerator, clamped so the quotient never exceeds 255
  always_comb begin
    rc_sum = lane_res.d_pos ? (24'(lane_res.base) - 24'(lane_res.prod))
                            : (24'(lane_res.base) + 24'(lane_res.prod));
    rc_neg = lane_res.d_pos && (lane_res.prod > 23'(lane_res.base));
    if (rc_neg) begin
      rc_num = '0;
    end else if (rc_sum > 24'(RCOMP_NUM_MAX)) begin
      rc_num = RCOMP_NUM_MAX;
    end else begin
      rc_num = rc_sum[17:0];
    end
  end

  always_comb begin
    div_req.start  = ((state_q == ST_MUL) && lane_res.done) ||
                     ((state_q == ST_CAP) && div_stat.done);
    div_req.narrow = (state_q == ST_CAP);
    div_num        = (state_q == ST_CAP) ? DIV_NUM_W'(rc_num) : cap_num;
    div_den        = (state_q == ST_CAP) ? RCOMP_SCALE : cap_den;
  end

  bgm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (div_den),
    .stat_o (div_stat)
  );

  assign cap_res = (div_stat.quo > DIV_QUO_W'(CAP_MAX)) ? CAP_MAX : div_stat.quo[6:0];

  // capacity decision and undervoltage tracking
  always_comb begin
    out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready_i);
    changed       = (cap_q != last_cap_q) || (cap_q == '0);
    want_recharge = health_q && nchg_q && (cap_q <= CAP_RECHARGE);
    uv_cnt_d      = uv_cnt_q;
    poll_d        = POLL_NONE;
    pwr_off_d     = 1'b0;
    if (cap_q == '0) begin
      if (booting_q) begin
        poll_d = POLL_BOOT;
      end else begin
        if (mv_q < low_mv_q) begin
          poll_d = POLL_FAST;
          if (uv_cnt_q != 2'd3) begin
            uv_cnt_d = uv_cnt_q + 1'b1;
          end
        end else begin
          poll_d   = POLL_NORMAL;
          uv_cnt_d = '0;
        end
        pwr_off_d = (uv_cnt_d == 2'd3);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcomp_base_q <= '0;
      coef_hot_q   <= '0;
      coef_cold_q  <= '0;
      full_q       <= 10'd1000;
      empty_q      <= '0;
      low_mv_q     <= 13'd3300;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RCOMP_BASE: rcomp_base_q <= cfg_data_i[7:0];
        REG_COEF_HOT:   coef_hot_q   <= cfg_data_i;
        REG_COEF_COLD:  coef_cold_q  <= cfg_data_i;
        REG_FULL_PT:    full_q       <= cfg_data_i[9:0];
        REG_EMPTY_PT:   empty_q      <= cfg_data_i[9:0];
        REG_LOW_MV:     low_mv_q     <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      last_cap_q <= '0;
      uv_cnt_q   <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i && !out_load) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (lane_res.done) begin
            state_q <= ST_CAP;
          end
        end
        ST_CAP: begin
          if (div_stat.done) begin
            state_q <= ST_RC;
          end
        end
        ST_RC: begin
          if (div_stat.done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state_q   <= ST_IDLE;
            m_valid_q <= 1'b1;
            uv_cnt_q  <= uv_cnt_d;
            if (changed) begin
              last_cap_q <= cap_q;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mv_q      <= mv_x5[14:2];
      booting_q <= s_axis_tdata_i[43];
      health_q  <= s_axis_tdata_i[44];
      nchg_q    <= s_axis_tdata_i[45];
    end
    if ((state_q == ST_CAP) && div_stat.done) begin
      cap_q <= cap_res;
    end
    if ((state_q == ST_RC) && div_stat.done) begin
      rcomp_q <= div_stat.quo[7:0];
    end
    if (out_load) begin
      o_cap_q      <= cap_q;
      o_mv_q       <= mv_q;
      o_rcomp_q    <= rcomp_q;
      o_recharge_q <= changed && want_recharge;
      o_notice_q   <= changed && !want_recharge;
      o_poll_q     <= poll_d;
      o_pwr_off_q  <= pwr_off_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'b0, o_pwr_off_q, o_poll_q, o_notice_q, o_recharge_q,
                            o_rcomp_q, o_mv_q, o_cap_q};

`ifndef NO_ASSERTIONS
  ap_pwr_off_needs_uv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && o_pwr_off_q |-> (o_cap_q == '0) && (o_poll_q == POLL_FAST))
    else $error("power-off without undervoltage at zero capacity");

  ap_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> !(o_recharge_q && o_notice_q))
    else $error("recharge and change notice both set");

  ap_poll_zero_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && (o_poll_q != POLL_NONE) |-> (o_cap_q == '0))
    else $error("repoll code with nonzero capacity");

  ap_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (o_cap_q <= CAP_MAX))
    else $error("capacity above 100");

  ap_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_CAP) || (state_q == ST_RC))
    else $error("divider finished outside a divide phase");

  ap_lane_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_res.done |-> (state_q == ST_MUL))
    else $error("multiply lanes finished outside the multiply phase");
`endif

endmodule

// ===== test/tb_battery_gauge_monitor_step_core.sv =====
// ----------------------------------------------------------------------------
// tb_battery_gauge_monitor_step_core
// Self-checking bench for the battery gauge poll processor. A short table of
// directed polls and register writes runs first, with hand-computed results
// for the reset settings. Several random phases with fresh register settings
// follow, each checked against a behavioral model of the capacity scaling,
// RCOMP compensation and undervoltage tracking. Both stream sides idle at
// random, except in two of the random phases.
// ----------------------------------------------------------------------------
module tb_battery_gauge_monitor_step_core;
  import bgm_pkg::*;

  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT  = 2000;
  localparam int N_PHASES     = 8;
  localparam int PHASE_POLLS  = 240;
  localparam int N_DIRECTED   = 38;

  // indexes past the register file, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef enum logic {ROW_POLL, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [15:0] charge;
    logic [15:0] volt;
    logic [10:0] temp;
    logic        booting;
    logic        health;
    logic        idle_chg;
  } poll_t;

  typedef struct packed {
    logic [6:0]  cap;
    logic [12:0] mv;
    logic [7:0]  rcomp;
    logic        recharge;
    logic        notice;
    logic [1:0]  poll;
    logic        power_off;
  } gauge_result_t;

  typedef struct packed {
    row_kind_e                kind;
    logic                     fixed_exp;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    val;
    poll_t                    poll;
    gauge_result_t            res;
  } stim_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid_i;
  logic                    s_axis_tready_o;
  logic [IN_TDATA_W-1:0]   s_axis_tdata_i;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;

  battery_gauge_monitor_step_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // model copy of registers and state
  logic [7:0]  m_base;
  logic [15:0] m_hot;
  logic [15:0] m_cold;
  logic [9:0]  m_full;
  logic [9:0]  m_empty;
  logic [12:0] m_low_mv;
  logic [6:0]  m_last_cap;
  logic [1:0]  m_uv_count;

  gauge_result_t pending_results [$];
  stim_row_t     dir_tab [N_DIRECTED];
  int            mismatches;
  int            quiet_cycles;
  bit            gaps_on;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic poll_t poll_of(int ch, int v, int t, int b, int h, int n);
    poll_t p;
    p.charge   = ch[15:0];
    p.volt     = v[15:0];
    p.temp     = t[10:0];
    p.booting  = b[0];
    p.health   = h[0];
    p.idle_chg = n[0];
    return p;
  endfunction

  function automatic gauge_result_t result_of(int cap, int mv, int rc, int rr, int cn,
                                              logic [1:0] pc, int po);
    gauge_result_t r;
    r.cap       = cap[6:0];
    r.mv        = mv[12:0];
    r.rcomp     = rc[7:0];
    r.recharge  = rr[0];
    r.notice    = cn[0];
    r.poll      = pc;
    r.power_off = po[0];
    return r;
  endfunction

  function automatic stim_row_t poll_row(poll_t p);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_POLL;
    r.poll = p;
    return r;
  endfunction

  function automatic stim_row_t fixed_row(poll_t p, gauge_result_t res);
    stim_row_t r;
    r           = poll_row(p);
    r.fixed_exp = 1'b1;
    r.res       = res;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, int val);
    stim_row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val[15:0];
    return r;
  endfunction

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int pick(int lo, int hi);
    case ($urandom_range(0, 5))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_poll(poll_t p);
    return {2'b00, p.idle_chg, p.health, p.booting, p.temp, p.volt, p.charge};
  endfunction

  // one poll through the model; updates last capacity and undervoltage count
  function automatic gauge_result_t gauge_predict(poll_t p);
    gauge_result_t r;
    longint ch, em, fu, num, den, q, val;
    int deg, coef, mv;
    r = '0;
    if (m_full > m_empty) begin
      ch  = p.charge;
      em  = m_empty;
      fu  = m_full;
      num = ch * 19531 - em * 1000000;
      den = (fu - em) * 10000;
      if (num >= 0) begin
        q     = num / den;
        r.cap = (q > 100) ? CAP_MAX : q[6:0];
      end
    end
    mv   = p.volt[15:4];
    mv   = (mv * 5) >> 2;
    r.mv = mv[12:0];

    deg  = $signed(p.temp);
    deg  = deg / 10;
    coef = (deg > 20) ? int'(m_hot) : (deg < 20) ? int'(m_cold) : 0;
    val  = m_base;
    val  = (val * 1000 - (deg - 20) * coef) / 1000;
    r.rcomp = (val < 0) ? 8'd0 : (val > 255) ? 8'd255 : val[7:0];

    if (r.cap != m_last_cap || r.cap == 0) begin
      if (p.health && p.idle_chg && r.cap <= CAP_RECHARGE) r.recharge = 1'b1;
      else r.notice = 1'b1;
      m_last_cap = r.cap;
    end

    r.poll = POLL_NONE;
    if (r.cap == 0) begin
      if (p.booting) begin
        r.poll = POLL_BOOT;
      end else begin
        if (r.mv < m_low_mv) begin
          r.poll = POLL_FAST;
          if (m_uv_count != 2'd3) m_uv_count = m_uv_count + 2'd1;
        end else begin
          r.poll     = POLL_NORMAL;
          m_uv_count = 2'd0;
        end
        r.power_off = (m_uv_count == 2'd3);
      end
    end
    return r;
  endfunction

  // random poll, biased toward zero capacity, repeats and threshold edges
  function automatic poll_t next_poll(poll_t prev, bit streak);
    poll_t p;
    int sel, ch, code, t, low_code, e_mark, f_mark;
    low_code = m_low_mv;
    low_code = low_code * 4 / 5;
    e_mark   = m_empty;
    e_mark   = e_mark * 1000000 / 19531;
    f_mark   = m_full;
    f_mark   = f_mark * 1000000 / 19531;

    sel = $urandom_range(0, 9);
    if (streak) ch = 0;
    else case (sel)
      0, 1: ch = 0;
      2, 3: ch = prev.charge;
      4, 5: ch = clip(e_mark + int'($urandom_range(0, 600)) - 300, 0, 65535);
      6:    ch = clip(f_mark + int'($urandom_range(0, 600)) - 300, 0, 65535);
      default: ch = $urandom_range(0, 65535);
    endcase

    sel = $urandom_range(0, 9);
    if (streak && sel < 8) code = $urandom_range(0, low_code);
    else if (sel < 4) code = clip(low_code + int'($urandom_range(0, 4)) - 2, 0, 4095);
    else if (sel == 4) code = $urandom_range(0, 1) ? 4095 : 0;
    else code = $urandom_range(0, 4095);

    case ($urandom_range(0, 7))
      0, 1: t = $urandom_range(185, 215);
      2:    t = int'($urandom_range(0, 30)) - 15;
      3:    t = $urandom_range(0, 1) ? 1000 : -400;
      default: t = int'($urandom_range(0, 1400)) - 400;
    endcase

    p = poll_of(ch, (code << 4) | int'($urandom_range(0, 15)), t,
                $urandom_range(0, 7) == 0, $urandom_range(0, 1), $urandom_range(0, 1));
    return p;
  endfunction

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[15:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_RCOMP_BASE: m_base   = val[7:0];
      REG_COEF_HOT:   m_hot    = val[15:0];
      REG_COEF_COLD:  m_cold   = val[15:0];
      REG_FULL_PT:    m_full   = val[9:0];
      REG_EMPTY_PT:   m_empty  = val[9:0];
      REG_LOW_MV:     m_low_mv = val[12:0];
      default: ;
    endcase
  endtask

  task automatic send_poll(poll_t p, bit fixed_exp, gauge_result_t want);
    gauge_result_t guess;
    cfg_valid_i <= 1'b0;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pack_poll(p);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    guess = gauge_predict(p);
    pending_results.push_back(fixed_exp ? want : guess);
  endtask

  // block idle: input held off, every result collected, then a drain wait
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic new_settings(int k);
    int fp, ep;
    case (k)
      0: begin
        write_reg(REG_RCOMP_BASE, 255);
        write_reg(REG_COEF_HOT, 65535);
        write_reg(REG_COEF_COLD, 65535);
        write_reg(REG_FULL_PT, 1000);
        write_reg(REG_EMPTY_PT, 0);
        write_reg(REG_LOW_MV, 5119);
      end
      1: begin
        write_reg(REG_RCOMP_BASE, 0);
        write_reg(REG_COEF_HOT, 0);
        write_reg(REG_COEF_COLD, 0);
        write_reg(REG_FULL_PT, 0);
        write_reg(REG_EMPTY_PT, 0);
        write_reg(REG_LOW_MV, 0);
      end
      default: begin
        fp = pick(0, 1000);
        if (fp == 0 || $urandom_range(0, 5) == 0) ep = $urandom_range(fp, 1000);
        else ep = pick(0, fp - 1);
        write_reg(REG_RCOMP_BASE, pick(0, 255));
        write_reg(REG_COEF_HOT, pick(0, 65535));
        write_reg(REG_COEF_COLD, pick(0, 65535));
        write_reg(REG_FULL_PT, fp);
        write_reg(REG_EMPTY_PT, ep);
        write_reg(REG_LOW_MV, pick(0, 5119));
      end
    endcase
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom_range(0, 65535));
  endtask

  // result side: random stall bursts while gaps are enabled
  initial begin : result_sink
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    gauge_result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.cap       = m_axis_tdata_o[6:0];
      got.mv        = m_axis_tdata_o[19:7];
      got.rcomp     = m_axis_tdata_o[27:20];
      got.recharge  = m_axis_tdata_o[28];
      got.notice    = m_axis_tdata_o[29];
      got.poll      = m_axis_tdata_o[31:30];
      got.power_off = m_axis_tdata_o[32];
      if (pending_results.size() == 0) begin
        flag_mismatch("result transaction with no poll outstanding");
      end else begin
        want = pending_results.pop_front();
        if (got.cap !== want.cap)
          flag_mismatch($sformatf("capacity_percent %0d, expected %0d", got.cap, want.cap));
        if (got.mv !== want.mv)
          flag_mismatch($sformatf("voltage_mv %0d, expected %0d", got.mv, want.mv));
        if (got.rcomp !== want.rcomp)
          flag_mismatch($sformatf("rcomp_byte %0d, expected %0d", got.rcomp, want.rcomp));
        if (got.recharge !== want.recharge)
          flag_mismatch($sformatf("recharge_request %b, expected %b",
                                  got.recharge, want.recharge));
        if (got.notice !== want.notice)
          flag_mismatch($sformatf("change_notice %b, expected %b", got.notice, want.notice));
        if (got.poll !== want.poll)
          flag_mismatch($sformatf("poll_code %0d, expected %0d", got.poll, want.poll));
        if (got.power_off !== want.power_off)
          flag_mismatch($sformatf("power_off_request %b, expected %b",
                                  got.power_off, want.power_off));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int streak;
    poll_t p, prev;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    rst_ni          <= 1'b0;
    gaps_on         = 1'b1;
    m_base          = 8'd0;
    m_hot           = 16'd0;
    m_cold          = 16'd0;
    m_full          = 10'd1000;
    m_empty         = 10'd0;
    m_low_mv        = 13'd3300;
    m_last_cap      = 7'd0;
    m_uv_count      = 2'd0;

    dir_tab = '{
      // reset settings: 0..100 % over raw 0..1000, threshold 3300 mV, RCOMP 0
      fixed_row(poll_of(0, 0, 0, 1, 0, 0), result_of(0, 0, 0, 0, 1, POLL_BOOT, 0)),
      fixed_row(poll_of(65535, 65535, 1000, 0, 1, 1),
                result_of(100, 5118, 0, 0, 1, POLL_NONE, 0)),
      fixed_row(poll_of(65535, 65535, 1000, 0, 1, 1),
                result_of(100, 5118, 0, 0, 0, POLL_NONE, 0)),
      // undervoltage run at zero capacity up to power-off
      fixed_row(poll_of(0, 0, -400, 0, 1, 1), result_of(0, 0, 0, 1, 0, POLL_FAST, 0)),
      fixed_row(poll_of(0, 0, -400, 0, 0, 1), result_of(0, 0, 0, 0, 1, POLL_FAST, 0)),
      fixed_row(poll_of(0, 0, -400, 0, 0, 1), result_of(0, 0, 0, 0, 1, POLL_FAST, 1)),
      fixed_row(poll_of(0, 0, -400, 0, 0, 1), result_of(0, 0, 0, 0, 1, POLL_FAST, 1)),
      // booting holds the count
      fixed_row(poll_of(0, 0, -400, 1, 0, 1), result_of(0, 0, 0, 0, 1, POLL_BOOT, 0)),
      fixed_row(poll_of(0, 0, -400, 0, 0, 1), result_of(0, 0, 0, 0, 1, POLL_FAST, 1)),
      // exactly at and just below the threshold
      fixed_row(poll_of(0, 'hA500, 0, 0, 0, 0), result_of(0, 3300, 0, 0, 1, POLL_NORMAL, 0)),
      fixed_row(poll_of(0, 'hA4F0, 0, 0, 0, 0), result_of(0, 3298, 0, 0, 1, POLL_FAST, 0)),
      // 99 % asks for recharge, 100 % only notifies
      fixed_row(poll_of(51200, 0, 0, 0, 1, 1), result_of(99, 0, 0, 1, 0, POLL_NONE, 0)),
      fixed_row(poll_of(51201, 0, 0, 0, 1, 1), result_of(100, 0, 0, 0, 1, POLL_NONE, 0)),
      cfg_row(REG_RCOMP_BASE, 128),
      cfg_row(REG_COEF_HOT, 1500),
      cfg_row(REG_COEF_COLD, 2500),
      cfg_row(REG_FULL_PT, 900),
      cfg_row(REG_EMPTY_PT, 100),
      cfg_row(REG_LOW_MV, 5119),
      cfg_row(REG_SPARE_LO, 'hFFFF),
      cfg_row(REG_SPARE_HI, 'h1234),
      // charge below empty, then the 20 degree boundaries
      poll_row(poll_of(5000, 'h8000, -400, 0, 1, 1)),
      poll_row(poll_of(5120, 'h8000, -5, 0, 0, 0)),
      poll_row(poll_of(5121, 'hFFFF, 199, 0, 1, 0)),
      poll_row(poll_of(30000, 'h4000, 200, 0, 1, 1)),
      poll_row(poll_of(30000, 'h4000, 209, 0, 1, 1)),
      poll_row(poll_of(40000, 'h1230, 210, 0, 0, 1)),
      poll_row(poll_of(65535, 'hFFFF, 1000, 0, 1, 1)),
      // full equal to empty
      cfg_row(REG_FULL_PT, 100),
      poll_row(poll_of(65535, 'h9000, 500, 0, 1, 1)),
      // RCOMP clamps at both ends
      cfg_row(REG_RCOMP_BASE, 255),
      cfg_row(REG_COEF_HOT, 65535),
      cfg_row(REG_COEF_COLD, 65535),
      cfg_row(REG_LOW_MV, 0),
      cfg_row(REG_FULL_PT, 1000),
      cfg_row(REG_EMPTY_PT, 0),
      poll_row(poll_of(0, 0, -400, 0, 1, 1)),
      poll_row(poll_of(25600, 0, 1000, 0, 0, 0))
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        if (i == 0 || dir_tab[i-1].kind != ROW_CFG) settle();
        write_reg(dir_tab[i].idx, dir_tab[i].val);
      end else begin
        send_poll(dir_tab[i].poll, dir_tab[i].fixed_exp, dir_tab[i].res);
      end
    end

    for (int k = 0; k < N_PHASES; k++) begin
      settle();
      gaps_on = (k != 3 && k != N_PHASES - 1);
      new_settings(k);
      streak = 0;
      prev   = '0;
      for (int n = 0; n < PHASE_POLLS; n++) begin
        // runs of zero-capacity polls drive the undervoltage counter
        if (streak == 0 && $urandom_range(0, 15) == 0) streak = $urandom_range(3, 6);
        p = next_poll(prev, streak != 0);
        if (streak != 0) streak--;
        send_poll(p, 1'b0, '0);
        prev = p;
      end
    end

    settle();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
